// ===== rtl/rgb_to_hsv_pixel_core_macros.svh =====
// ---------------------------------------------------------------------------
// rgb to hsv pixel core assertion macros
// shared property forms for the checks at the end of the top level
// ---------------------------------------------------------------------------
`ifndef RGB_TO_HSV_PIXEL_CORE_MACROS_SVH
`define RGB_TO_HSV_PIXEL_CORE_MACROS_SVH

// same-cycle implication, idle during reset
`define RHSV_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("rhsv check failed: same-cycle implication");

// next-cycle implication, idle during reset
`define RHSV_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("rhsv check failed: next-cycle implication");

`endif

// ===== rtl/rhsv_pkg.sv =====
// ---------------------------------------------------------------------------
// rhsv_pkg
// types, constants and helpers shared by the rgb to hsv pixel core
// ---------------------------------------------------------------------------
package rhsv_pkg;

    localparam int CHAN_W    = 8;
    localparam int HUE_W     = 13;
    localparam int HUE_DVD_W = 18;   // 960 * 255 fits
    localparam int HUE_Q_W   = 10;   // quotient never exceeds 960
    localparam int SAT_DVD_W = 16;   // 255 * 255 fits
    localparam int SAT_Q_W   = 8;
    localparam int SUM_W     = 10;

    localparam logic [HUE_W-1:0] HUE_FULL_TURN = 13'd5760;
    localparam logic [HUE_W-1:0] HUE_OFS_RED   = 13'd0;
    localparam logic [HUE_W-1:0] HUE_OFS_GREEN = 13'd1920;
    localparam logic [HUE_W-1:0] HUE_OFS_BLUE  = 13'd3840;

    // floor(sum/3) == (sum*683) >> 11 for every sum up to 765
    localparam logic [SUM_W-1:0] MEAN_RECIP = 10'd683;
    localparam int               MEAN_SHIFT = 11;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } t_sector;

    // sideband carried through the hue divider
    typedef struct packed {
        t_sector                sector;
        logic                   neg;
        logic [CHAN_W-1:0]      mean;
        logic [CHAN_W-1:0]      bright;
        logic [SAT_DVD_W-1:0]   sat_dvd;
        logic [CHAN_W-1:0]      sat_dvs;
    } t_side;

    // front end result
    typedef struct packed {
        logic [HUE_DVD_W-1:0]   hue_dvd;
        logic [CHAN_W-1:0]      hue_dvs;
        t_side                  side;
    } t_front;

    // sideband carried through the saturation divider
    typedef struct packed {
        t_sector                sector;
        logic                   neg;
        logic [CHAN_W-1:0]      mean;
        logic [CHAN_W-1:0]      bright;
        logic [HUE_Q_W-1:0]     hue_q;
        logic                   hue_rnz;
    } t_sat_side;

    function automatic logic [HUE_W-1:0] hue_offset(input t_sector sector);
        logic [HUE_W-1:0] ofs;
        case (sector)
            SECT_RED:   ofs = HUE_OFS_RED;
            SECT_GREEN: ofs = HUE_OFS_GREEN;
            SECT_BLUE:  ofs = HUE_OFS_BLUE;
            default:    ofs = HUE_OFS_RED;
        endcase
        return ofs;
    endfunction

endpackage

// ===== rtl/rhsv_front.sv =====
// ---------------------------------------------------------------------------
// rhsv_front
// two-stage front end: channel max/min, sector, mean and divider operands
// ---------------------------------------------------------------------------
module rhsv_front import rhsv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CHAN_W-1:0] i_red,
    input  logic [CHAN_W-1:0] i_green,
    input  logic [CHAN_W-1:0] i_blue,
    output logic              o_valid,
    input  logic              i_ready,
    output t_front            o_front
);

    // stage one registers
    logic              r1_vld;
    logic [CHAN_W-1:0] r1_bright, r1_min, r1_pos, r1_neg;
    t_sector           r1_sector;
    logic [SUM_W-1:0]  r1_sum;

    logic [CHAN_W-1:0] n1_bright, n1_min, n1_pos, n1_neg;
    t_sector           n1_sector;
    logic [SUM_W-1:0]  n1_sum;

    // stage two registers
    logic   r2_vld;
    t_front r2_front;
    t_front n2_front;

    logic w_rdy1, w_rdy2;

    logic [CHAN_W-1:0]       w_delta, w_mag;
    logic [2*SUM_W-1:0]      w_mean_prod;

    assign w_rdy2  = !r2_vld || i_ready;
    assign w_rdy1  = !r1_vld || w_rdy2;
    assign o_ready = w_rdy1;

    always_comb begin
        n1_bright = i_red;
        if (i_green > n1_bright) n1_bright = i_green;
        if (i_blue > n1_bright)  n1_bright = i_blue;
        n1_min = i_red;
        if (i_green < n1_min) n1_min = i_green;
        if (i_blue < n1_min)  n1_min = i_blue;
        // ties go to red, then green
        if (i_red >= i_green && i_red >= i_blue) begin
            n1_sector = SECT_RED;
            n1_pos    = i_green;
            n1_neg    = i_blue;
        end else if (i_green >= i_blue) begin
            n1_sector = SECT_GREEN;
            n1_pos    = i_blue;
            n1_neg    = i_red;
        end else begin
            n1_sector = SECT_BLUE;
            n1_pos    = i_red;
            n1_neg    = i_green;
        end
        n1_sum = SUM_W'(i_red) + SUM_W'(i_green) + SUM_W'(i_blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_rdy1) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_bright <= n1_bright;
            r1_min    <= n1_min;
            r1_pos    <= n1_pos;
            r1_neg    <= n1_neg;
            r1_sector <= n1_sector;
            r1_sum    <= n1_sum;
        end
    end

    assign w_delta     = r1_bright - r1_min;
    assign w_mean_prod = (2*SUM_W)'(r1_sum) * (2*SUM_W)'(MEAN_RECIP);

    always_comb begin
        if (r1_pos >= r1_neg) begin
            w_mag             = r1_pos - r1_neg;
            n2_front.side.neg = 1'b0;
        end else begin
            w_mag             = r1_neg - r1_pos;
            n2_front.side.neg = 1'b1;
        end
        // 960 = 1024 - 64, 255 = 256 - 1
        n2_front.hue_dvd = (HUE_DVD_W'(w_mag) << 10) - (HUE_DVD_W'(w_mag) << 6);
        // a zero divisor only meets a zero dividend, so 1 keeps the quotient at zero
        n2_front.hue_dvs = (w_delta == '0) ? CHAN_W'(1) : w_delta;
        n2_front.side.sector  = r1_sector;
        n2_front.side.mean    = w_mean_prod[MEAN_SHIFT +: CHAN_W];
        n2_front.side.bright  = r1_bright;
        n2_front.side.sat_dvd = (SAT_DVD_W'(w_delta) << 8) - SAT_DVD_W'(w_delta);
        n2_front.side.sat_dvs = (r1_bright == '0) ? CHAN_W'(1) : r1_bright;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_rdy2) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_front <= n2_front;
        end
    end

    assign o_valid = r2_vld;
    assign o_front = r2_front;

endmodule

// ===== rtl/rhsv_div.sv =====
// ---------------------------------------------------------------------------
// rhsv_div
// pipelined restoring divider, one quotient bit per stage, with sideband
// ---------------------------------------------------------------------------
module rhsv_div import rhsv_pkg::*; #(
    parameter int DW = 18,
    parameter int VW = 8,
    parameter int QW = 10,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [QW-1:0] o_quotient,
    output logic          o_rem_nz,
    output logic [SW-1:0] o_side
);

    // working width holds both the remainder and the shifted divisor
    localparam int LW = (DW > VW + QW) ? DW : VW + QW;

    logic [QW-1:0] r_vld;
    logic [DW-1:0] r_rem  [QW];
    logic [VW-1:0] r_dvs  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [SW-1:0] r_side [QW];
    logic [QW-1:0] w_rdy;

    genvar gs;
    generate
        for (gs = 0; gs < QW; gs++) begin : g_stage
            localparam int J = QW - 1 - gs;

            logic          a_vld, a_nxt_rdy;
            logic [DW-1:0] a_rem;
            logic [VW-1:0] a_dvs;
            logic [QW-1:0] a_quo;
            logic [SW-1:0] a_side;
            logic [LW-1:0] w_rem_x, w_dsh;
            logic [DW-1:0] n_rem;
            logic [QW-1:0] n_quo;

            if (gs == 0) begin : g_first
                assign a_vld  = i_valid;
                assign a_rem  = i_dividend;
                assign a_dvs  = i_divisor;
                assign a_quo  = '0;
                assign a_side = i_side;
            end else begin : g_rest
                assign a_vld  = r_vld[gs-1];
                assign a_rem  = r_rem[gs-1];
                assign a_dvs  = r_dvs[gs-1];
                assign a_quo  = r_quo[gs-1];
                assign a_side = r_side[gs-1];
            end

            if (gs == QW - 1) begin : g_last
                assign a_nxt_rdy = i_ready;
            end else begin : g_mid
                assign a_nxt_rdy = w_rdy[gs+1];
            end

            assign w_rdy[gs] = !r_vld[gs] || a_nxt_rdy;

            assign w_rem_x = LW'(a_rem);
            assign w_dsh   = LW'(a_dvs) << J;

            always_comb begin
                if (w_rem_x >= w_dsh) begin
                    n_rem = DW'(w_rem_x - w_dsh);
                    n_quo = a_quo | (QW'(1) << J);
                end else begin
                    n_rem = a_rem;
                    n_quo = a_quo;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[gs] <= 1'b0;
                end else if (w_rdy[gs]) begin
                    r_vld[gs] <= a_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[gs]) begin
                    r_rem[gs]  <= n_rem;
                    r_dvs[gs]  <= a_dvs;
                    r_quo[gs]  <= n_quo;
                    r_side[gs] <= a_side;
                end
            end
        end
    endgenerate

    assign o_ready    = w_rdy[0];
    assign o_valid    = r_vld[QW-1];
    assign o_quotient = r_quo[QW-1];
    assign o_rem_nz   = (r_rem[QW-1] != '0);
    assign o_side     = r_side[QW-1];

endmodule

// ===== rtl/rgb_to_hsv_pixel_core.sv =====
// ---------------------------------------------------------------------------
// rgb_to_hsv_pixel_core
// streaming rgb pixel to hue, saturation, value and channel mean
// ---------------------------------------------------------------------------
// one pixel beat in on the s_axis side, one result beat out on m_axis.
// an accepted input beat reaches m_axis through two front-end stages
// (max/min, then divider operands and mean), ten hue divider stages,
// eight saturation divider stages and the output register. throughput is
// one pixel per clock while m_axis_tready stays high; every stage holds
// its own valid bit, so the two dividers and the output register take a
// new beat each cycle as long as the next stage moves.
// when m_axis_tready is low the output register holds its beat and the
// stages behind it keep filling any empty slots before s_axis_tready
// drops; nothing is lost or repeated.
// reset clears all valid bits; the pipeline is empty and ready on the
// first cycle after reset. hue is in sixteenths of a degree (0..5759),
// saturation 0..255, value is the largest channel, mean is floor(sum/3).
// ---------------------------------------------------------------------------
`include "rgb_to_hsv_pixel_core_macros.svh"

module rgb_to_hsv_pixel_core import rhsv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // hue[12:0], saturation[20:13],
                                        // brightness[28:21], mean_level[36:29], zero[39:37]
);

    logic      w_front_vld, w_front_rdy;
    t_front    w_front;
    logic      w_hue_vld, w_hue_rdy;
    logic [HUE_Q_W-1:0] w_hue_q;
    logic      w_hue_rnz;
    t_side     w_hue_side;
    t_sat_side w_sat_in;
    logic      w_sat_vld, w_out_rdy;
    logic [SAT_Q_W-1:0] w_sat_q;
    t_sat_side w_sat_side;

    logic              r_out_vld;
    logic [39:0]       r_out_data;
    logic [39:0]       n_out_data;
    logic [HUE_W-1:0]  w_ofs, w_step, n_hue;

    // output fields, for the checks
    logic [HUE_W-1:0]  w_hue_o;
    logic [CHAN_W-1:0] w_sat_o, w_val_o, w_mean_o;

    rhsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_red   (s_axis_tdata[7:0]),
        .i_green (s_axis_tdata[15:8]),
        .i_blue  (s_axis_tdata[23:16]),
        .o_valid (w_front_vld),
        .i_ready (w_front_rdy),
        .o_front (w_front)
    );

    rhsv_div #(
        .DW (HUE_DVD_W),
        .VW (CHAN_W),
        .QW (HUE_Q_W),
        .SW ($bits(t_side))
    ) u_hue_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_front_vld),
        .o_ready    (w_front_rdy),
        .i_dividend (w_front.hue_dvd),
        .i_divisor  (w_front.hue_dvs),
        .i_side     (w_front.side),
        .o_valid    (w_hue_vld),
        .i_ready    (w_hue_rdy),
        .o_quotient (w_hue_q),
        .o_rem_nz   (w_hue_rnz),
        .o_side     (w_hue_side)
    );

    always_comb begin
        w_sat_in.sector  = w_hue_side.sector;
        w_sat_in.neg     = w_hue_side.neg;
        w_sat_in.mean    = w_hue_side.mean;
        w_sat_in.bright  = w_hue_side.bright;
        w_sat_in.hue_q   = w_hue_q;
        w_sat_in.hue_rnz = w_hue_rnz;
    end

    rhsv_div #(
        .DW (SAT_DVD_W),
        .VW (CHAN_W),
        .QW (SAT_Q_W),
        .SW ($bits(t_sat_side))
    ) u_sat_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_hue_vld),
        .o_ready    (w_hue_rdy),
        .i_dividend (w_hue_side.sat_dvd),
        .i_divisor  (w_hue_side.sat_dvs),
        .i_side     (w_sat_in),
        .o_valid    (w_sat_vld),
        .i_ready    (w_out_rdy),
        .o_quotient (w_sat_q),
        .o_rem_nz   (),
        .o_side     (w_sat_side)
    );

    // negative side takes the ceiling, so the hue is floored toward minus infinity
    assign w_ofs  = hue_offset(w_sat_side.sector);
    assign w_step = HUE_W'(w_sat_side.hue_q)
                  + HUE_W'(w_sat_side.neg & w_sat_side.hue_rnz);

    always_comb begin
        if (!w_sat_side.neg) begin
            n_hue = w_ofs + w_step;
        end else if (w_ofs >= w_step) begin
            n_hue = w_ofs - w_step;
        end else begin
            // red sector below zero wraps round the full turn
            n_hue = w_ofs + HUE_FULL_TURN - w_step;
        end
        n_out_data = {3'b000, w_sat_side.mean, w_sat_side.bright, w_sat_q, n_hue};
    end

    assign w_out_rdy = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_rdy) begin
            r_out_vld <= w_sat_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_rdy) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    assign w_hue_o  = m_axis_tdata[12:0];
    assign w_sat_o  = m_axis_tdata[20:13];
    assign w_val_o  = m_axis_tdata[28:21];
    assign w_mean_o = m_axis_tdata[36:29];

    // a coloured hue always comes with non-zero saturation
    `RHSV_ASSERT_IMPLY(a_hue_sat, i_clk, i_rst_n, m_axis_tvalid && (w_hue_o != '0), w_sat_o != '0)
    // black pixel has neither hue nor saturation
    `RHSV_ASSERT_IMPLY(a_black_sat, i_clk, i_rst_n, m_axis_tvalid && (w_val_o == '0), w_sat_o == '0)
    `RHSV_ASSERT_IMPLY(a_black_hue, i_clk, i_rst_n, m_axis_tvalid && (w_val_o == '0), w_hue_o == '0)
    // mean never exceeds the largest channel
    `RHSV_ASSERT_IMPLY(a_mean, i_clk, i_rst_n, m_axis_tvalid, w_mean_o <= w_val_o)
    // a finished divider beat always lands in the output register
    `RHSV_ASSERT_NEXT(a_fill, i_clk, i_rst_n, w_sat_vld, m_axis_tvalid)

endmodule

// ===== tb/sv/tb_rgb_to_hsv_pixel_core.sv =====
// ---------------------------------------------------------------------------
// tb_rgb_to_hsv_pixel_core
// self-checking bench for the streaming rgb to hsv pixel core
// ---------------------------------------------------------------------------
// pixels go in on s_axis and every accepted beat is converted by a local
// integer model; the expected hue, saturation, value and mean are queued
// and compared field by field with each beat taken from m_axis. the tests
// run a directed set of corner pixels, randomised streams with gaps on both
// sides, an unbroken stream and a long output hold-off that backs the
// pipeline up into the input.
// ---------------------------------------------------------------------------
module tb_rgb_to_hsv_pixel_core import rhsv_pkg::*; ();

    localparam int HUE_SECTOR_SPAN = 960;
    localparam int DRAIN_CYCLES    = 30;    // a little over the pipeline depth
    localparam int STALL_LIMIT     = 2000;  // cycles with no beat on either side
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int IDLE_PERCENT    = 16;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_pixel;

    typedef struct packed {
        logic [2:0]        pad;
        logic [CHAN_W-1:0] mean_level;
        logic [CHAN_W-1:0] brightness;
        logic [CHAN_W-1:0] saturation;
        logic [HUE_W-1:0]  hue;
    } t_hsv_beat;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;    // red[7:0], green[15:8], blue[23:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // hue[12:0], saturation[20:13],
                                        // brightness[28:21], mean_level[36:29], zero[39:37]

    t_hsv_beat hsv_pending[$];
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    int        hold_request   = 0;
    bit        tx_idle_en     = 1'b0;
    bit        rx_idle_en     = 1'b0;

    rgb_to_hsv_pixel_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // integer conversion of one pixel, floors taken toward minus infinity
    function automatic t_hsv_beat predict_hsv(input t_pixel px);
        int        r;
        int        g;
        int        b;
        int        mx;
        int        mn;
        int        delta;
        int        num;
        int        h;
        t_sector   sect;
        t_hsv_beat res;
        r = px.red;
        g = px.green;
        b = px.blue;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        res = '0;
        res.brightness = CHAN_W'(mx);
        res.mean_level = CHAN_W'((r + g + b) / 3);
        if (mx != 0) res.saturation = CHAN_W'((255 * delta) / mx);
        if (delta != 0) begin
            // ties go to red first, then green
            if (r == mx) begin
                sect = SECT_RED;
                num  = g - b;
            end else if (g == mx) begin
                sect = SECT_GREEN;
                num  = b - r;
            end else begin
                sect = SECT_BLUE;
                num  = r - g;
            end
            case (sect)
                SECT_GREEN: h = int'(HUE_OFS_GREEN);
                SECT_BLUE:  h = int'(HUE_OFS_BLUE);
                default:    h = int'(HUE_OFS_RED);
            endcase
            if (num >= 0) h = h + (HUE_SECTOR_SPAN * num) / delta;
            else          h = h - (HUE_SECTOR_SPAN * (-num) + delta - 1) / delta;
            if (h < 0) h = h + int'(HUE_FULL_TURN);
            if (h >= int'(HUE_FULL_TURN)) h = h - int'(HUE_FULL_TURN);
            res.hue = HUE_W'(h);
        end
        return res;
    endfunction

    function automatic t_pixel make_pixel(input int r, input int g, input int b);
        t_pixel px;
        px.red   = CHAN_W'(r);
        px.green = CHAN_W'(g);
        px.blue  = CHAN_W'(b);
        return px;
    endfunction

    function automatic int corner_level();
        int pick;
        pick = $urandom_range(3);
        case (pick)
            0:       return 0;
            1:       return 1;
            2:       return 254;
            default: return 255;
        endcase
    endfunction

    // uniform pixels half the time, else greys, near greys, tied maxima, corners or a zero channel
    function automatic t_pixel random_pixel();
        int kind;
        int m;
        int lo;
        kind = $urandom_range(9);
        m    = $urandom_range(255);
        case (kind)
            5: return make_pixel(m, m, m);
            6: begin
                lo = (m > 252) ? 252 : m;
                return make_pixel(lo + $urandom_range(3), lo + $urandom_range(3),
                                  lo + $urandom_range(3));
            end
            7: begin
                lo = $urandom_range(m);
                case ($urandom_range(2))
                    0:       return make_pixel(m, m, lo);
                    1:       return make_pixel(lo, m, m);
                    default: return make_pixel(m, lo, m);
                endcase
            end
            8: return make_pixel(corner_level(), corner_level(), corner_level());
            9: begin
                case ($urandom_range(2))
                    0:       return make_pixel(0, $urandom_range(255), $urandom_range(255));
                    1:       return make_pixel($urandom_range(255), 0, $urandom_range(255));
                    default: return make_pixel($urandom_range(255), $urandom_range(255), 0);
                endcase
            end
            default: return make_pixel($urandom_range(255), $urandom_range(255),
                                       $urandom_range(255));
        endcase
    endfunction

    // offer one pixel and wait for the input beat, queueing its conversion
    task automatic send_pixel(input t_pixel px);
        while (tx_idle_en && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        hsv_pending.push_back(predict_hsv(px));
    endtask

    task automatic test_directed_pixels();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_pixel(make_pixel(0, 0, 0));         // black
        send_pixel(make_pixel(255, 255, 255));   // white
        send_pixel(make_pixel(128, 128, 128));   // grey
        send_pixel(make_pixel(255, 0, 0));
        send_pixel(make_pixel(0, 255, 0));
        send_pixel(make_pixel(0, 0, 255));
        send_pixel(make_pixel(255, 255, 0));     // red and green tie
        send_pixel(make_pixel(0, 255, 255));     // green and blue tie
        send_pixel(make_pixel(255, 0, 255));     // red and blue tie
        send_pixel(make_pixel(255, 0, 1));       // red sector wraps below zero
        send_pixel(make_pixel(200, 10, 50));
        send_pixel(make_pixel(1, 0, 0));
        send_pixel(make_pixel(0, 1, 0));
        send_pixel(make_pixel(0, 0, 1));
        send_pixel(make_pixel(254, 255, 253));
        send_pixel(make_pixel(10, 20, 30));
        send_pixel(make_pixel(255, 128, 0));
        send_pixel(make_pixel(8'hAA, 8'h55, 8'hAA));
        send_pixel(make_pixel(8'h55, 8'hAA, 8'h55));
        send_pixel(make_pixel(1, 1, 0));
        send_pixel(make_pixel(255, 254, 255));
    endtask

    task automatic test_random_stream(input int count);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (count) send_pixel(random_pixel());
    endtask

    task automatic test_unbroken_stream(input int count);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (count) send_pixel(random_pixel());
    endtask

    // output held off while pixels keep coming, so the input backs up
    task automatic test_output_hold_off(input int count);
        tx_idle_en   = 1'b0;
        rx_idle_en   = 1'b0;
        hold_request = HOLD_OFF_CYCLES;
        repeat (count) send_pixel(random_pixel());
    endtask

    // receiver ready, with random stalls and an occasional long hold-off
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left = hold_left - 1;
            end else if (rx_idle_en && $urandom_range(99) < IDLE_PERCENT) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_hsv_beat got;
        t_hsv_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_hsv_beat'(m_axis_tdata);
            if (hsv_pending.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result beat %h", m_axis_tdata);
            end else begin
                want = hsv_pending.pop_front();
                if (got.hue !== want.hue || got.saturation !== want.saturation ||
                    got.brightness !== want.brightness ||
                    got.mean_level !== want.mean_level || got.pad !== want.pad) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch exp/act: hue %0d/%0d sat %0d/%0d val %0d/%0d",
                                 want.hue, got.hue, want.saturation, got.saturation,
                                 want.brightness, got.brightness,
                                 " mean %0d/%0d pad %0d/%0d",
                                 want.mean_level, got.mean_level, want.pad, got.pad);
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_pixels();
        test_random_stream(500);
        test_output_hold_off(120);
        test_random_stream(400);
        test_unbroken_stream(150);
        test_random_stream(100);

        s_axis_tvalid <= 1'b0;
        while (hsv_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rhsv_pkg.sv
rtl/rhsv_front.sv
rtl/rhsv_div.sv
rtl/rgb_to_hsv_pixel_core.sv
tb/sv/tb_rgb_to_hsv_pixel_core.sv
